FILE: src/cfp_pkg.sv
// shared types, constants and register codes for the crystal fit position clamp
// depends on nothing; imported by every module of the block but the checker
`timescale 1ns / 1ps

package cfp_pkg;

   localparam int GRID_SIDE   = 4;
   localparam int CELL_W      = 4;
   localparam int SPAN_W      = 27;
   localparam int DIST_W      = 29;
   localparam int PROD_W      = 41;
   localparam int ABS_W       = 40;
   localparam int DIVIDEND_W  = 42;
   localparam int DIVISOR_W   = 17;
   localparam int DIV_STEPS   = 6;
   localparam int DIV_STAGES  = DIVIDEND_W / DIV_STEPS;
   localparam int FIT_W       = 44;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [17:0] TOWER_PITCH_RST    = 18'd95872;
   localparam logic [17:0] CRYSTAL_LENGTH_RST = 18'd83456;

   typedef enum logic [2:0] {
      CSR_TOWER_PITCH    = 3'd0,
      CSR_CRYSTAL_LENGTH = 3'd1,
      CSR_FLIGHT_GEOM    = 3'd2,
      CSR_LONG_INVALID   = 3'd3,
      CSR_NEAR_EDGE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [17:0] tower_pitch;
      logic [17:0] crystal_length;
      logic        flight_geometry;
      logic [17:0] long_invalid_distance;
      logic [17:0] near_edge_distance;
   } cfg_type;

   typedef struct packed {
      logic                     no_fit;
      logic signed [23:0]       base;
      logic signed [SPAN_W-1:0] lo2;
      logic signed [SPAN_W-1:0] hi2;
      logic                     near_end;
      logic signed [PROD_W-1:0] prod;
      logic signed [15:0]       axis_z;
      logic signed [23:0]       cl;
   } queue_item_type;

   typedef struct packed {
      logic                     no_fit;
      logic signed [23:0]       base;
      logic signed [SPAN_W-1:0] lo2;
      logic signed [SPAN_W-1:0] hi2;
      logic                     near_end;
      logic                     neg;
      logic signed [23:0]       cl;
      logic [DIVISOR_W-1:0]     rem;
      logic [DIVISOR_W-1:0]     dv;
      logic [DIVIDEND_W-1:0]    quo;
   } stage_type;

endpackage

FILE: src/cfp_front.sv
// front end: classifies a request, builds the crystal span and the fit numerator
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_front import cfp_pkg::*; (
   input  logic               along_x,
   input  logic [3:0]         tower_index,
   input  logic signed [23:0] base_long,
   input  logic signed [23:0] base_z,
   input  logic signed [23:0] centroid_long,
   input  logic signed [23:0] centroid_z,
   input  logic signed [15:0] axis_long,
   input  logic signed [15:0] axis_z,
   input  logic [3:0]         fit_layers,
   input  cfg_type            cfg,
   output queue_item_type     item
);

   localparam logic signed [SPAN_W-1:0] SIDE_M1 = SPAN_W'(GRID_SIDE - 1);

   logic [CELL_W-1:0]        tower_cell;
   logic [21:0]              pc;
   logic signed [SPAN_W-1:0] pitch_s, len_s, pc2_s, off2, lo2, hi2;
   logic                     use_grid;
   logic signed [DIST_W-1:0] b2, lo2e, hi2e, da, db, mn;
   logic [DIST_W-1:0]        lid2;
   logic signed [24:0]       dz;

   assign tower_cell = along_x ? CELL_W'(tower_index % GRID_SIDE)
                               : CELL_W'(tower_index / GRID_SIDE);
   assign pc       = cfg.tower_pitch * tower_cell;
   assign pitch_s  = $signed({{(SPAN_W-18){1'b0}}, cfg.tower_pitch});
   assign len_s    = $signed({{(SPAN_W-18){1'b0}}, cfg.crystal_length});
   assign pc2_s    = $signed({{(SPAN_W-23){1'b0}}, pc, 1'b0});
   assign off2     = pc2_s - pitch_s * SIDE_M1;
   assign use_grid = along_x | cfg.flight_geometry;
   assign lo2      = use_grid ? off2 - len_s : -len_s;
   assign hi2      = use_grid ? off2 + len_s : len_s;

   // distance of the base coordinate to the nearer end, in half units
   assign b2   = $signed({{(DIST_W-25){base_long[23]}}, base_long, 1'b0});
   assign lo2e = $signed({{(DIST_W-SPAN_W){lo2[SPAN_W-1]}}, lo2});
   assign hi2e = $signed({{(DIST_W-SPAN_W){hi2[SPAN_W-1]}}, hi2});
   assign lid2 = {{(DIST_W-19){1'b0}}, cfg.long_invalid_distance, 1'b0};

   always_comb begin
      da = b2 - lo2e;
      if (da < 0) begin
         da = -da;
      end
      db = b2 - hi2e;
      if (db < 0) begin
         db = -db;
      end
      mn = (da < db) ? da : db;
   end

   assign dz = {base_z[23], base_z} - {centroid_z[23], centroid_z};

   always_comb begin
      item.no_fit   = (fit_layers == 4'd0) || (axis_z == 16'sd0);
      item.base     = base_long;
      item.lo2      = lo2;
      item.hi2      = hi2;
      item.near_end = $unsigned(mn) < lid2;
      item.prod     = dz * axis_long;
      item.axis_z   = axis_z;
      item.cl       = centroid_long;
   end

endmodule

FILE: src/cfp_queue.sv
// short queue that decouples the front end from the divide back end
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_queue import cfp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  queue_item_type wr_item,
   output logic           rd_valid,
   input  logic           rd_pop,
   output queue_item_type rd_item
);

   queue_item_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push, pop;

   assign wr_ready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_pop & rd_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

FILE: src/cfp_back.sv
// back end: pipelined rounding divide, extrapolation, clamping, flags, response register
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_back import cfp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   output logic           q_pop,
   input  queue_item_type q_item,
   input  logic [17:0]    near_edge_distance,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [31:0]    rsp_data
);

   typedef struct packed {
      logic                    no_fit;
      logic signed [23:0]      base;
      logic signed [SPAN_W-1:0] lo2;
      logic signed [SPAN_W-1:0] hi2;
      logic                    near_end;
      logic signed [FIT_W-1:0] fit;
   } fit_item_type;

   logic                   adv;
   logic [DIV_STAGES:0]    vld_ff;
   stage_type              st_ff [DIV_STAGES+1];
   stage_type              st_in [DIV_STAGES+1];
   logic                   fit_vld_ff;
   fit_item_type           fit_ff, fit_in;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_data_ff, rsp_data_in;

   logic [ABS_W-1:0]       un;
   logic [15:0]            ud;
   logic signed [PROD_W-1:0] neg_prod;

   assign adv   = ~rsp_valid_ff | rsp_ready;
   assign q_pop = adv & q_valid;

   // load stage: magnitudes and the rounding offset
   always_comb begin
      neg_prod = -q_item.prod;
      un = q_item.prod[PROD_W-1] ? neg_prod[ABS_W-1:0] : q_item.prod[ABS_W-1:0];
      ud = q_item.axis_z[15] ? 16'(-q_item.axis_z) : q_item.axis_z;
      st_in[0].no_fit   = q_item.no_fit;
      st_in[0].base     = q_item.base;
      st_in[0].lo2      = q_item.lo2;
      st_in[0].hi2      = q_item.hi2;
      st_in[0].near_end = q_item.near_end;
      st_in[0].neg      = q_item.prod[PROD_W-1] ^ q_item.axis_z[15];
      st_in[0].cl       = q_item.cl;
      st_in[0].rem      = '0;
      st_in[0].dv       = {ud, 1'b0};
      st_in[0].quo      = DIVIDEND_W'({un, 1'b0}) + DIVIDEND_W'(ud);
   end

   // restoring divide, quotient bits shift in behind the dividend
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_comb begin
         logic [DIVISOR_W:0] t;
         stage_type          s;
         s = st_ff[k-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            t     = {s.rem, s.quo[DIVIDEND_W-1]};
            s.quo = {s.quo[DIVIDEND_W-2:0], 1'b0};
            if (t >= {1'b0, s.dv}) begin
               t        = t - {1'b0, s.dv};
               s.quo[0] = 1'b1;
            end
            s.rem = t[DIVISOR_W-1:0];
         end
         st_in[k] = s;
      end
   end

   always_comb begin
      logic signed [FIT_W-1:0] sq, clx;
      stage_type               s;
      s   = st_ff[DIV_STAGES];
      sq  = $signed({{(FIT_W-DIVIDEND_W){1'b0}}, s.quo});
      clx = $signed({{(FIT_W-24){s.cl[23]}}, s.cl});
      fit_in.no_fit   = s.no_fit;
      fit_in.base     = s.base;
      fit_in.lo2      = s.lo2;
      fit_in.hi2      = s.hi2;
      fit_in.near_end = s.near_end;
      fit_in.fit      = s.neg ? clx - sq : clx + sq;
   end

   always_comb begin
      logic signed [FIT_W:0]   fit2, lo2e, hi2e, da, db, mn, ned2, lo_end, hi_end;
      logic signed [FIT_W-1:0] res;
      logic                    below, above, in_span, near_edge;
      logic [23:0]             cor;
      fit2   = {fit_ff.fit, 1'b0};
      lo2e   = $signed({{(FIT_W+1-SPAN_W){fit_ff.lo2[SPAN_W-1]}}, fit_ff.lo2});
      hi2e   = $signed({{(FIT_W+1-SPAN_W){fit_ff.hi2[SPAN_W-1]}}, fit_ff.hi2});
      ned2   = $signed({{(FIT_W-18){1'b0}}, near_edge_distance, 1'b0});
      below  = fit2 < lo2e;
      above  = fit2 > hi2e;
      in_span = (fit2 > lo2e) && (fit2 < hi2e);
      da     = fit2 - lo2e;
      db     = hi2e - fit2;
      mn     = (da < db) ? da : db;
      near_edge = in_span && (mn < ned2);
      // lower end rounds up, upper end rounds down
      lo_end = (lo2e + 1) >>> 1;
      hi_end = hi2e >>> 1;
      if (below) begin
         res = lo_end[FIT_W-1:0];
      end else if (above) begin
         res = hi_end[FIT_W-1:0];
      end else begin
         res = fit_ff.fit;
      end
      if (res > FIT_W'(8388607)) begin
         cor = 24'h7fffff;
      end else if (res < -FIT_W'(8388608)) begin
         cor = 24'h800000;
      end else begin
         cor = res[23:0];
      end
      if (fit_ff.no_fit) begin
         rsp_data_in = {8'd0, fit_ff.base};
      end else begin
         rsp_data_in = {4'd0, below | above, near_edge, fit_ff.near_end, 1'b1, cor};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         fit_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[DIV_STAGES-1:0], q_valid};
         fit_vld_ff   <= vld_ff[DIV_STAGES];
         rsp_valid_ff <= fit_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
         fit_ff      <= fit_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/crystal_fit_position_clamp.sv
// top level of the crystal fit position clamp: ports, control registers, front, queue, back
// depends on cfp_pkg, cfp_front, cfp_queue, cfp_back
`timescale 1ns / 1ps

// One request per crystal hit, one response per request, in order. The block
// takes a request every cycle while the queue is not full (a stalled response
// side fills it); an accepted request passes through the queue into the load
// stage, seven divide stages of six quotient bits each, the extrapolation stage
// and the flag stage into the response register. The pipeline depth is set by
// the 42-bit rounding divide of the fit numerator by the axis z component.
// A four-entry queue sits between the span/multiply front end and the divide
// pipeline, so request and response sides stall independently. Control
// registers are written on the csr port, which is always ready; write them
// only while no request is in flight.

module crystal_fit_position_clamp import cfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tower_index, base_long, base_z, centroid_long, centroid_z, axis_long,
   // axis_z, fit_layers
   input  logic [135:0] req_tdata,
   // along_x
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // corrected_long, fit_available, base_near_end, fit_near_edge, fit_clamped, zero fill
   output logic [31:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [17:0]  csr_data
);

   cfg_type        cfg_ff, cfg_in;
   queue_item_type front_item, q_item;
   logic           q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TOWER_PITCH:    cfg_in.tower_pitch           = csr_data;
            CSR_CRYSTAL_LENGTH: cfg_in.crystal_length        = csr_data;
            CSR_FLIGHT_GEOM:    cfg_in.flight_geometry       = csr_data[0];
            CSR_LONG_INVALID:   cfg_in.long_invalid_distance = csr_data;
            CSR_NEAR_EDGE:      cfg_in.near_edge_distance    = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tower_pitch           <= TOWER_PITCH_RST;
         cfg_ff.crystal_length        <= CRYSTAL_LENGTH_RST;
         cfg_ff.flight_geometry       <= 1'b1;
         cfg_ff.long_invalid_distance <= '0;
         cfg_ff.near_edge_distance    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfp_front u_front (
      .along_x       (req_tuser[0]),
      .tower_index   (req_tdata[3:0]),
      .base_long     ($signed(req_tdata[27:4])),
      .base_z        ($signed(req_tdata[51:28])),
      .centroid_long ($signed(req_tdata[75:52])),
      .centroid_z    ($signed(req_tdata[99:76])),
      .axis_long     ($signed(req_tdata[115:100])),
      .axis_z        ($signed(req_tdata[131:116])),
      .fit_layers    (req_tdata[135:132]),
      .cfg           (cfg_ff),
      .item          (front_item)
   );

   cfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_item  (front_item),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_item  (q_item)
   );

   cfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_item             (q_item),
      .near_edge_distance (cfg_ff.near_edge_distance),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_data           (rsp_tdata)
   );

endmodule

FILE: src/cfp_checker.sv
// port-level checks for the crystal fit position clamp, bound to the top level
// depends on crystal_fit_position_clamp
`timescale 1ns / 1ps

module cfp_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata
);

   a_rsp_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // no correction means no flags
   a_no_fit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |-> rsp_tdata[27:25] == 3'b000)
      else $error("flag set without a fit");

   // a clamped fit is never flagged as near the edge
   a_clamp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[26] && rsp_tdata[27]))
      else $error("near edge and clamped together");

endmodule

bind crystal_fit_position_clamp cfp_checker u_cfp_checker (.*);
